// ===== sv/linear_blend_skinning_core_assert.svh =====
// assertion macros used by the skinning core back end
`ifndef LINEAR_BLEND_SKINNING_CORE_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lbs_pkg.sv =====
// types, codes and helpers of the skinning core
`timescale 1ns / 1ps

package lbs_pkg;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         bone_index;
        logic [3:0]         element_index;
        logic signed [31:0] word;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic [16:0]        weight;
        logic               first_influence;
        logic               last_influence;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               saturated;
    } t_out_item;

    localparam logic CMD_WRITE = 1'b0;

    typedef enum logic [1:0] {
        K_DROP,
        K_WRITE,
        K_INFL,
        K_INFL_ZERO
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_item item;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_ROUND,
        S_WEIGHT,
        S_SUM,
        S_EMIT
    } t_state;

    localparam logic [3:0] WORDS_PER_BONE = 4'd12;
    localparam logic [1:0] LAST_COL       = 2'd3;
    localparam logic [1:0] LAST_ROW       = 2'd2;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] f_sat(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic f_ovf(input logic signed [63:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

endpackage

// ===== sv/lbs_front.sv =====
// front end: accepts transactions, classifies them and queues them
`timescale 1ns / 1ps

module lbs_front #(
    parameter int MAX_BONES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lbs_pkg::t_in_item i_in_data,
    output logic             o_q_valid,
    input  logic             i_q_ready,
    output lbs_pkg::t_entry  o_q_entry
);

    localparam int QD = 2;
    localparam int PW = $clog2(QD);

    lbs_pkg::t_entry r_q [QD];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [PW:0]     r_count;

    lbs_pkg::t_entry w_cls;
    logic            w_bone_ok;
    logic            w_push;
    logic            w_pop;

    assign w_bone_ok = 32'(i_in_data.bone_index) < MAX_BONES;

    always_comb begin
        w_cls.item = i_in_data;
        if (i_in_data.cmd == lbs_pkg::CMD_WRITE) begin
            w_cls.kind = (w_bone_ok && (i_in_data.element_index < lbs_pkg::WORDS_PER_BONE))
                         ? lbs_pkg::K_WRITE : lbs_pkg::K_DROP;
        end else begin
            w_cls.kind = w_bone_ok ? lbs_pkg::K_INFL : lbs_pkg::K_INFL_ZERO;
        end
    end

    assign o_in_ready = r_count < (PW+1)'(QD);
    assign o_q_valid  = r_count != '0;
    assign o_q_entry  = r_q[r_rd];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= w_cls;
                r_wr      <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/lbs_back.sv =====
// back end: palette memory, transform sequencer, accumulators, output register
`timescale 1ns / 1ps
`include "linear_blend_skinning_core_assert.svh"

module lbs_back #(
    parameter int MAX_BONES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  lbs_pkg::t_entry   i_q_entry,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lbs_pkg::t_out_item o_out_data
);

    localparam int PAL_DEPTH = MAX_BONES * 12;
    localparam int AW        = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

    logic [31:0] r_pal [PAL_DEPTH];

    lbs_pkg::t_state    r_state;
    lbs_pkg::t_state    n_state;
    lbs_pkg::t_entry    r_item;
    logic [1:0]         r_row;
    logic [1:0]         r_col;
    logic [31:0]        r_rdata;
    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;
    logic signed [31:0] r_tword;
    logic signed [31:0] r_t;
    logic signed [49:0] r_wprod;
    logic signed [31:0] r_sum [3];
    logic               r_clip;
    logic               r_out_valid;
    lbs_pkg::t_out_item r_out;

    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_addr;
    logic [5:0]         w_bone;
    logic [3:0]         w_elem;
    logic signed [31:0] w_data;
    logic signed [31:0] w_off;
    logic signed [63:0] w_prod;
    logic signed [65:0] w_acc_rnd;
    logic signed [63:0] w_tfull;
    logic signed [49:0] w_wmul;
    logic signed [49:0] w_wrnd;
    logic signed [63:0] w_snew;
    logic               w_single;
    logic               w_pop;

    // palette address: bone * 12 + word
    always_comb begin
        if (r_state == lbs_pkg::S_IDLE) begin
            w_bone = i_q_entry.item.bone_index;
            w_elem = i_q_entry.item.element_index;
        end else begin
            w_bone = r_item.item.bone_index;
            w_elem = {r_row, r_col};
        end
    end
    assign mem_addr = AW'(10'(w_bone) * 10'd12 + 10'(w_elem));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pal[mem_addr] <= i_q_entry.item.word;
        end
        if (mem_re) begin
            r_rdata <= r_pal[mem_addr];
        end
    end

    // datapath
    assign w_data = (r_item.kind == lbs_pkg::K_INFL_ZERO) ? 32'sd0 : signed'(r_rdata);

    always_comb begin
        case (r_col)
            2'd0:    w_off = r_item.item.offset_x;
            2'd1:    w_off = r_item.item.offset_y;
            default: w_off = r_item.item.offset_z;
        endcase
    end

    assign w_prod    = 64'(w_data) * 64'(w_off);
    assign w_acc_rnd = r_acc + 66'sd32768;
    assign w_tfull   = 64'(signed'(w_acc_rnd[65:16])) + 64'(r_tword);
    assign w_wmul    = 50'(r_t) * 50'(signed'({1'b0, r_item.item.weight}));
    assign w_wrnd    = r_wprod + 50'sd32768;
    assign w_snew    = 64'(r_sum[r_row]) + 64'(signed'(w_wrnd[49:16]));
    assign w_single  = r_item.item.first_influence && r_item.item.last_influence;
    assign w_pop     = i_q_valid && o_q_ready;

    // sequencer
    always_comb begin
        n_state   = r_state;
        o_q_ready = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        unique case (r_state)
            lbs_pkg::S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    unique case (i_q_entry.kind)
                        lbs_pkg::K_WRITE: mem_we = 1'b1;
                        lbs_pkg::K_DROP:  n_state = lbs_pkg::S_IDLE;
                        default:          n_state = lbs_pkg::S_READ;
                    endcase
                end
            end
            lbs_pkg::S_READ: begin
                mem_re  = 1'b1;
                n_state = lbs_pkg::S_MUL;
            end
            lbs_pkg::S_MUL: begin
                n_state = (r_col == lbs_pkg::LAST_COL) ? lbs_pkg::S_ROUND : lbs_pkg::S_ACC;
            end
            lbs_pkg::S_ACC:    n_state = lbs_pkg::S_READ;
            lbs_pkg::S_ROUND:  n_state = lbs_pkg::S_WEIGHT;
            lbs_pkg::S_WEIGHT: n_state = lbs_pkg::S_SUM;
            lbs_pkg::S_SUM: begin
                if (r_row == lbs_pkg::LAST_ROW) begin
                    n_state = r_item.item.last_influence ? lbs_pkg::S_EMIT : lbs_pkg::S_IDLE;
                end else begin
                    n_state = lbs_pkg::S_READ;
                end
            end
            lbs_pkg::S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = lbs_pkg::S_IDLE;
                end
            end
            default: n_state = lbs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_clip      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lbs_pkg::S_EMIT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                lbs_pkg::S_IDLE: begin
                    if (w_pop && (i_q_entry.kind == lbs_pkg::K_INFL
                                  || i_q_entry.kind == lbs_pkg::K_INFL_ZERO)) begin
                        r_item <= i_q_entry;
                        r_row  <= '0;
                        r_col  <= '0;
                        r_acc  <= '0;
                        if (i_q_entry.item.first_influence) begin
                            r_sum[0] <= '0;
                            r_sum[1] <= '0;
                            r_sum[2] <= '0;
                            r_clip   <= 1'b0;
                        end
                    end
                end
                lbs_pkg::S_MUL: begin
                    if (r_col == lbs_pkg::LAST_COL) begin
                        r_tword <= w_data;
                    end else begin
                        r_prod <= w_prod;
                    end
                end
                lbs_pkg::S_ACC: begin
                    r_acc <= r_acc + 66'(r_prod);
                    r_col <= r_col + 2'd1;
                end
                lbs_pkg::S_ROUND: begin
                    r_t <= lbs_pkg::f_sat(w_tfull);
                    if (lbs_pkg::f_ovf(w_tfull)) begin
                        r_clip <= 1'b1;
                    end
                end
                lbs_pkg::S_WEIGHT: r_wprod <= w_wmul;
                lbs_pkg::S_SUM: begin
                    if (w_single) begin
                        r_sum[r_row] <= r_t;
                    end else begin
                        r_sum[r_row] <= lbs_pkg::f_sat(w_snew);
                        if (lbs_pkg::f_ovf(w_snew)) begin
                            r_clip <= 1'b1;
                        end
                    end
                    r_row <= r_row + 2'd1;
                    r_col <= '0;
                    r_acc <= '0;
                end
                lbs_pkg::S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.pos_x     <= r_sum[0];
                        r_out.pos_y     <= r_sum[1];
                        r_out.pos_z     <= r_sum[2];
                        r_out.saturated <= r_clip;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LBS_ASSERT_NOW(a_emit_last, r_state == lbs_pkg::S_EMIT, r_item.item.last_influence, "emit without last influence")
    `LBS_ASSERT_NOW(a_we_idle, mem_we, r_state == lbs_pkg::S_IDLE && i_q_entry.kind == lbs_pkg::K_WRITE, "palette write outside idle")
    `LBS_ASSERT_NOW(a_round_col, r_state == lbs_pkg::S_ROUND, r_col == lbs_pkg::LAST_COL, "rounding before translation word")
    `LBS_ASSERT_NEXT(a_row_end, r_state == lbs_pkg::S_SUM && r_row == lbs_pkg::LAST_ROW && !r_item.item.last_influence, r_state == lbs_pkg::S_IDLE, "inner influence did not finish")

endmodule

// ===== sv/linear_blend_skinning_core.sv =====
// a palette write is queued, then written to the memory once the sequencer is idle
// a closing influence leaves the queue, then each matrix row passes the read, multiply,
// accumulate, round, weight and sum states, and the result loads the output register
// the sequencer takes one item at a time; a 2-entry queue keeps accepting meanwhile
// reset: synchronous active low, clears queue, sequencer, sums and clip flag
`timescale 1ns / 1ps

module linear_blend_skinning_core #(
    parameter int MAX_BONES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transactions
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lbs_pkg::t_in_item  i_in_data,
    // result transactions
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lbs_pkg::t_out_item o_out_data
);

    // queue between front and back
    logic            q_valid;
    logic            q_ready;
    lbs_pkg::t_entry q_entry;

    // front end classifies palette writes and influences, marks bad writes for dropping
    lbs_front #(
        .MAX_BONES (MAX_BONES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_entry  (q_entry)
    );

    // back end walks each matrix row word by word, then weights and accumulates
    // palette contents are undefined until written
    lbs_back #(
        .MAX_BONES (MAX_BONES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_entry   (q_entry),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== dv/lbs_checker.sv =====
// result predictor and checker for the skinning core
`timescale 1ns / 1ps

module lbs_checker #(
    parameter int MAX_BONES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  lbs_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  lbs_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [31:0] palette [MAX_BONES*12];
    logic signed [63:0] acc_x, acc_y, acc_z;
    logic acc_clip;
    lbs_pkg::t_out_item expected_positions[$];

    function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                   inout logic clip);
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] mat_word(input int bone, input int elem);
        if (bone >= MAX_BONES) return 64'sd0;
        return 64'(signed'(palette[bone*12 + elem]));
    endfunction

    // one row of the bone transform, rounded half up and clamped
    function automatic logic signed [63:0] row_of(input int bone, input int row,
                                                  input lbs_pkg::t_in_item it,
                                                  inout logic clip);
        logic signed [63:0] o [3];
        logic signed [63:0] p;
        logic signed [63:0] hi;
        logic [63:0] lo;
        o[0] = 64'(it.offset_x);
        o[1] = 64'(it.offset_y);
        o[2] = 64'(it.offset_z);
        hi = 0;
        lo = 0;
        for (int c = 0; c < 3; c++) begin
            p = mat_word(bone, row*4 + c) * o[c];
            hi += floor16(p);
            lo += {48'd0, p[15:0]};
        end
        hi += $signed((lo + 64'h8000) >> 16);
        hi += mat_word(bone, row*4 + 3);
        return clamp32(hi, clip);
    endfunction

    task automatic apply_item(input lbs_pkg::t_in_item it);
        logic signed [63:0] t [3];
        logic signed [63:0] term;
        logic clip;
        lbs_pkg::t_out_item r;
        clip = 1'b0;
        if (it.cmd == lbs_pkg::CMD_WRITE) begin
            if (it.bone_index < MAX_BONES && it.element_index < lbs_pkg::WORDS_PER_BONE)
                palette[it.bone_index*12 + it.element_index] = it.word;
            return;
        end
        if (it.first_influence) begin
            acc_x = 0; acc_y = 0; acc_z = 0; acc_clip = 1'b0;
        end
        for (int rr = 0; rr < 3; rr++) t[rr] = row_of(it.bone_index, rr, it, clip);
        if (it.first_influence && it.last_influence) begin
            acc_x = t[0]; acc_y = t[1]; acc_z = t[2];
        end else begin
            term = floor16(t[0] * $signed({47'd0, it.weight}) + 64'sh8000);
            acc_x = clamp32(acc_x + term, clip);
            term = floor16(t[1] * $signed({47'd0, it.weight}) + 64'sh8000);
            acc_y = clamp32(acc_y + term, clip);
            term = floor16(t[2] * $signed({47'd0, it.weight}) + 64'sh8000);
            acc_z = clamp32(acc_z + term, clip);
        end
        if (clip) acc_clip = 1'b1;
        if (it.last_influence) begin
            r.pos_x = acc_x[31:0];
            r.pos_y = acc_y[31:0];
            r.pos_z = acc_z[31:0];
            r.saturated = acc_clip;
            expected_positions.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        lbs_pkg::t_out_item e;
        if (!i_rst_n) begin
            acc_x = 0; acc_y = 0; acc_z = 0; acc_clip = 1'b0;
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_positions.size() == 0) begin
                    $display("%0t: unexpected position x=%h y=%h z=%h sat=%b", $time,
                             i_out_data.pos_x, i_out_data.pos_y, i_out_data.pos_z,
                             i_out_data.saturated);
                    o_fail_count++;
                end else begin
                    e = expected_positions.pop_front();
                    if (e !== i_out_data) begin
                        $display("%0t: position mismatch expected %h %h %h %b got %h %h %h %b",
                                 $time, e.pos_x, e.pos_y, e.pos_z, e.saturated,
                                 i_out_data.pos_x, i_out_data.pos_y, i_out_data.pos_z,
                                 i_out_data.saturated);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) apply_item(i_in_data);
        end
        o_pending = expected_positions.size();
    end

endmodule

// ===== dv/tb_linear_blend_skinning_core.sv =====
// stimulus and verdict for the skinning core
`timescale 1ns / 1ps

module tb_linear_blend_skinning_core;

    localparam int NUM_BONES = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    lbs_pkg::t_in_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    lbs_pkg::t_out_item out_data;
    int fail_count;
    int pending;
    bit written [NUM_BONES];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    linear_blend_skinning_core #(.MAX_BONES(NUM_BONES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    lbs_checker #(.MAX_BONES(NUM_BONES)) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // moderate values in two of five draws, else a full-range word or a 32-bit extreme
    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // one transaction on the input side, optional idle gap first; valid stays up when
    // the next transaction follows with no gap
    task automatic send(input lbs_pkg::t_in_item it);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_word(input int bone, input int elem, input logic [31:0] w);
        lbs_pkg::t_in_item it;
        it = '0;
        it.cmd = lbs_pkg::CMD_WRITE;
        it.bone_index = 6'(bone);
        it.element_index = 4'(elem);
        it.word = w;
        it.weight = 17'($urandom());
        it.offset_x = $urandom();
        it.first_influence = 1'($urandom_range(0, 1));
        it.last_influence = 1'($urandom_range(0, 1));
        send(it);
    endtask

    // whole matrix of a bone, so later reads never see unwritten words
    task automatic write_bone(input int bone, input bit extreme);
        for (int e = 0; e < 12; e++) begin
            if (extreme) write_word(bone, e, rand_q16());
            else if (e % 5 == 0) write_word(bone, e, 32'h0001_0000);
            else write_word(bone, e, $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
        end
        written[bone] = 1'b1;
    endtask

    task automatic influence(input int bone, input logic [16:0] w,
                             input bit first, input bit last, input bit wide);
        lbs_pkg::t_in_item it;
        it = '0;
        it.cmd = ~lbs_pkg::CMD_WRITE;
        it.bone_index = 6'(bone);
        it.element_index = 4'($urandom());
        it.word = $urandom();
        it.offset_x = wide ? $urandom() : rand_q16();
        it.offset_y = wide ? $urandom() : rand_q16();
        it.offset_z = wide ? $urandom() : rand_q16();
        it.weight = w;
        it.first_influence = first;
        it.last_influence = last;
        send(it);
    endtask

    function automatic int pick_bone();
        int b;
        do b = $urandom_range(0, NUM_BONES - 1); while (!written[b]);
        return b;
    endfunction

    // result side: random stalls, with some long runs of always-ready
    initial begin
        int free_run;
        free_run = 0;
        forever begin
            @(negedge i_clk);
            if (free_run > 0) begin
                free_run--;
                out_ready <= 1'b1;
            end else if ($urandom_range(0, 199) == 0) begin
                free_run = $urandom_range(100, 400);
                out_ready <= 1'b1;
            end else begin
                out_ready <= (gap_len() == 0);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("linear_blend_skinning_core test failed");
        $finish;
    end

    initial begin
        int n_infl;
        int sent;
        logic [16:0] w;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: palette extremes, out of range element, single and multi influence
        write_bone(0, 1'b0);
        write_word(1, 0, 32'h7fffffff);
        write_word(1, 1, 32'h80000000);
        write_word(1, 2, 32'hffffffff);
        for (int e = 3; e < 12; e++) write_word(1, e, 32'h7fffffff);
        write_word(63, 15, 32'h12345678);
        write_bone(63, 1'b0);
        influence(0, 17'd65536, 1, 1, 0);
        influence(1, 17'd0, 1, 1, 1);
        influence(1, 17'h1ffff, 1, 0, 1);
        influence(0, 17'd65536, 0, 1, 0);
        influence(63, 17'd32768, 1, 0, 0);
        influence(0, 17'd0, 0, 0, 0);
        influence(63, 17'h1ffff, 0, 1, 0);
        influence(0, 17'd65536, 0, 1, 0);
        for (int b = 2; b < 6; b++) write_bone(b, 1'($urandom_range(0, 1)));

        // random: mostly well formed vertices, some palette rewrites and broken flags
        sent = 0;
        while (sent < 1000) begin
            if ($urandom_range(0, 9) == 0) begin
                write_word($urandom_range(0, NUM_BONES - 1), $urandom_range(0, 15), rand_q16());
                sent++;
            end else if ($urandom_range(0, 29) == 0) begin
                write_bone($urandom_range(0, NUM_BONES - 1), $urandom_range(0, 3) == 0);
                sent += 12;
            end else if ($urandom_range(0, 14) == 0) begin
                influence(pick_bone(), 17'($urandom()), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                n_infl = $urandom_range(1, 4);
                for (int k = 0; k < n_infl; k++) begin
                    w = ($urandom_range(0, 7) == 0) ? 17'd65536
                                                    : 17'($urandom_range(0, 32768));
                    influence(pick_bone(), w, k == 0, k == n_infl - 1,
                              $urandom_range(0, 9) == 0);
                end
                sent += n_infl;
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("linear_blend_skinning_core test passed");
        end else begin
            $display("linear_blend_skinning_core test failed");
        end
        $finish;
    end
endmodule
